// ===== sv/arst_pkg.sv =====
`timescale 1ns / 1ps

package arst_pkg;

  localparam int ID_W  = 16;
  localparam int SEQ_W = 32;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_SEND  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // One table row: claimed peer id, last received and last sent sequence
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] rx;
    logic [SEQ_W-1:0] tx;
  } row_t;

  // Outcome of one read-modify-write on a claimed row
  typedef struct packed {
    logic             accepted;
    logic [SEQ_W-1:0] seq;
    row_t             row;
  } upd_t;

endpackage

// ===== sv/arst_update.sv =====
`timescale 1ns / 1ps

module arst_update import arst_pkg::*; (
  input  logic             command,
  input  logic [ID_W-1:0]  peer_id,
  input  logic [SEQ_W-1:0] received_sequence,
  input  row_t             row_in,
  output upd_t             upd
);

  logic [SEQ_W-1:0] tx_inc;

  assign tx_inc = row_in.tx + SEQ_W'(1);

  // Claim the row for the peer, then apply the check or the send
  always_comb begin
    upd          = '0;
    upd.row      = row_in;
    upd.row.id   = peer_id;
    upd.accepted = 1'b0;
    upd.seq      = '0;
    if (command == CMD_CHECK) begin
      // accept only a strictly newer sequence
      if (row_in.rx < received_sequence) begin
        upd.row.rx   = received_sequence;
        upd.accepted = 1'b1;
      end
    end else begin
      upd.row.tx   = tx_inc;
      upd.seq      = tx_inc;
      upd.accepted = 1'b1;
    end
  end

endmodule

// ===== sv/anti_replay_sequence_table.sv =====
`timescale 1ns / 1ps

// Per-peer replay check and send sequence source.
// An item (command, is_broadcast, peer_id, received_sequence) is taken at a
// rising edge with start high and busy low. Each item gives one result:
// done is high for exactly one cycle with accepted, sequence_out and
// table_full valid in that cycle; the receiver cannot stall and the result
// fields keep their values until the next result.
// A broadcast send needs no lookup: done is raised in the cycle after the
// item is taken and busy stays low. Any other item scans its table slot by
// slot through one synchronous memory read per cycle, stops at the first
// free or matching slot, then writes the row back; a full table ends the
// scan with table_full. The next item may start in the cycle done is shown.
// Slots are claimed in order, so a fill count per table marks rows never
// written, which read as zero.
// Reset (rst, synchronous) empties both tables and clears the broadcast
// send counter at once; there is no clearing pass.
module anti_replay_sequence_table import arst_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             command,
  input  logic             is_broadcast,
  input  logic [ID_W-1:0]  peer_id,
  input  logic [SEQ_W-1:0] received_sequence,
  output logic             done,
  output logic             accepted,
  output logic [SEQ_W-1:0] sequence_out,
  output logic             table_full
);

  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W   = IDX_W + 1;
  localparam int DEPTH    = 2 ** ADDR_W;
  localparam int LAST_IDX = TABLE_ENTRIES - 1;

  state_t state, state_next;

  // latched item
  logic             cmd_q;
  logic             bc_q;
  logic [ID_W-1:0]  peer_q;
  logic [SEQ_W-1:0] rx_q;

  // scan control
  logic [IDX_W-1:0] rd_idx;
  logic             rd_stop;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic [IDX_W-1:0] slot_q;
  row_t             row_q;

  // table state
  row_t             mem [DEPTH];
  row_t             rd_row;
  row_t             rd_row_m;
  logic [CNT_W-1:0] bcast_fill;
  logic [CNT_W-1:0] ucast_fill;
  logic [CNT_W-1:0] cur_fill;
  logic [SEQ_W-1:0] bcast_tx_counter;
  logic [SEQ_W-1:0] bcast_tx_inc;

  logic             take;
  logic             bcast_send;
  logic             hit;
  logic             scan_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  upd_t             upd;

  assign busy         = (state != ST_IDLE);
  assign take         = start && (state == ST_IDLE);
  assign bcast_send   = (command == CMD_SEND) && is_broadcast;
  assign bcast_tx_inc = bcast_tx_counter + SEQ_W'(1);
  assign cur_fill     = bc_q ? bcast_fill : ucast_fill;
  assign rd_addr      = {bc_q, rd_idx};
  assign wr_addr      = {bc_q, slot_q};

  // Rows at or beyond the fill count were never written: read as zero
  assign rd_row_m  = (CNT_W'(chk_idx) < cur_fill) ? rd_row : '0;
  assign hit       = chk_valid && ((rd_row_m.id == '0) || (rd_row_m.id == peer_q));
  assign scan_full = chk_valid && !hit && (chk_idx == IDX_W'(LAST_IDX));

  arst_update u_update (
    .command           (cmd_q),
    .peer_id           (peer_q),
    .received_sequence (rx_q),
    .row_in            (row_q),
    .upd               (upd)
  );

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the scan state machine
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !bcast_send) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_UPDATE;
        end else if (scan_full) begin
          state_next = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: scan pointer, fill counts, broadcast counter, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      rd_idx           <= '0;
      rd_stop          <= 1'b0;
      chk_valid        <= 1'b0;
      bcast_fill       <= '0;
      ucast_fill       <= '0;
      bcast_tx_counter <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            rd_idx    <= '0;
            rd_stop   <= 1'b0;
            chk_valid <= 1'b0;
            if (bcast_send) begin
              bcast_tx_counter <= bcast_tx_inc;
              done             <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          // issue one read a cycle until the last slot
          chk_valid <= !rd_stop;
          if (!rd_stop) begin
            if (rd_idx == IDX_W'(LAST_IDX)) begin
              rd_stop <= 1'b1;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (scan_full) begin
            done <= 1'b1;
          end
        end
        ST_UPDATE: begin
          done <= 1'b1;
          // a claim of the first unwritten row grows the fill count
          if (CNT_W'(slot_q) == cur_fill) begin
            if (bc_q) begin
              bcast_fill <= cur_fill + CNT_W'(1);
            end else begin
              ucast_fill <= cur_fill + CNT_W'(1);
            end
          end
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // Payload registers: latched item, claimed row, result fields
  always_ff @(posedge clk) begin
    chk_idx <= rd_idx;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd_q  <= command;
          bc_q   <= is_broadcast;
          peer_q <= peer_id;
          rx_q   <= received_sequence;
          if (bcast_send) begin
            accepted     <= 1'b1;
            sequence_out <= bcast_tx_inc;
            table_full   <= 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          slot_q <= chk_idx;
          row_q  <= rd_row_m;
        end else if (scan_full) begin
          accepted     <= 1'b0;
          sequence_out <= '0;
          table_full   <= 1'b1;
        end
      end
      ST_UPDATE: begin
        accepted     <= upd.accepted;
        sequence_out <= upd.seq;
        table_full   <= 1'b0;
      end
      default: begin
        table_full <= 1'b0;
      end
    endcase
  end

  // Table memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
    if (state == ST_UPDATE) begin
      mem[wr_addr] <= upd.row;
    end
  end

endmodule

// ===== tb/replay_table_checker.sv =====
`timescale 1ns / 1ps

module replay_table_checker import arst_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             command,
  input  logic             is_broadcast,
  input  logic [ID_W-1:0]  peer_id,
  input  logic [SEQ_W-1:0] received_sequence,
  input  logic             done,
  input  logic             accepted,
  input  logic [SEQ_W-1:0] sequence_out,
  input  logic             table_full,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic             acc;
    logic [SEQ_W-1:0] seq;
    logic             full;
  } verdict_t;

  verdict_t verdict_q[$];

  // Shadow copy of both peer tables and the broadcast send counter
  logic [ID_W-1:0]  bc_id  [TABLE_ENTRIES];
  logic [SEQ_W-1:0] bc_rx  [TABLE_ENTRIES];
  logic [ID_W-1:0]  uc_id  [TABLE_ENTRIES];
  logic [SEQ_W-1:0] uc_rx  [TABLE_ENTRIES];
  logic [SEQ_W-1:0] uc_tx  [TABLE_ENTRIES];
  logic [SEQ_W-1:0] bc_tx_count;
  int               reported;

  // Take the first slot that is free or already holds the peer, and claim it
  function automatic int claim_slot(input logic bcast, input logic [ID_W-1:0] peer);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (bcast) begin
        if (bc_id[i] == '0 || bc_id[i] == peer) begin
          bc_id[i] = peer;
          return i;
        end
      end else begin
        if (uc_id[i] == '0 || uc_id[i] == peer) begin
          uc_id[i] = peer;
          return i;
        end
      end
    end
    return -1;
  endfunction

  // Advance the shadow state by one item and return its result
  function automatic verdict_t replay_verdict(input cmd_t cmd, input logic bcast,
                                              input logic [ID_W-1:0] peer,
                                              input logic [SEQ_W-1:0] rx);
    verdict_t v;
    int       slot;
    v = '0;
    if (cmd == CMD_CHECK) begin
      slot = claim_slot(bcast, peer);
      if (slot < 0) begin
        v.full = 1'b1;
      end else if (bcast) begin
        if (bc_rx[slot] < rx) begin
          bc_rx[slot] = rx;
          v.acc = 1'b1;
        end
      end else begin
        if (uc_rx[slot] < rx) begin
          uc_rx[slot] = rx;
          v.acc = 1'b1;
        end
      end
    end else if (bcast) begin
      bc_tx_count = bc_tx_count + SEQ_W'(1);
      v.seq = bc_tx_count;
      v.acc = 1'b1;
    end else begin
      slot = claim_slot(1'b0, peer);
      if (slot < 0) begin
        v.full = 1'b1;
      end else begin
        uc_tx[slot] = uc_tx[slot] + SEQ_W'(1);
        v.seq = uc_tx[slot];
        v.acc = 1'b1;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        bc_id[i] = '0;
        bc_rx[i] = '0;
        uc_id[i] = '0;
        uc_rx[i] = '0;
        uc_tx[i] = '0;
      end
      bc_tx_count = '0;
      verdict_q.delete();
      errors = 0;
      reported = 0;
    end else begin
      // Compare the result shown this cycle against the oldest prediction
      if (done) begin
        got = '{acc: accepted, seq: sequence_out, full: table_full};
        if (verdict_q.size() == 0) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result acc=%0b seq=%h full=%0b",
                     $realtime, got.acc, got.seq, got.full);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got.acc !== want.acc || got.seq !== want.seq || got.full !== want.full) begin
            errors++;
            if (reported < 10) begin
              reported++;
              $display({"%0t: mismatch expected acc=%0b seq=%h full=%0b,",
                        " got acc=%0b seq=%h full=%0b"},
                       $realtime, want.acc, want.seq, want.full,
                       got.acc, got.seq, got.full);
            end
          end
        end
      end
      // Predict every item the block takes
      if (start && !busy) begin
        verdict_q.push_back(replay_verdict(cmd_t'(command), is_broadcast, peer_id,
                                           received_sequence));
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== tb/tb_anti_replay_sequence_table.sv =====
`timescale 1ns / 1ps

module tb_anti_replay_sequence_table;
  import arst_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDLE_LIMIT    = 1000;
  localparam int RANDOM_ITEMS  = 1230;
  localparam int POOL_SIZE     = 18;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             command = CMD_CHECK;
  logic             is_broadcast = 1'b0;
  logic [ID_W-1:0]  peer_id = '0;
  logic [SEQ_W-1:0] received_sequence = '0;
  logic             done;
  logic             accepted;
  logic [SEQ_W-1:0] sequence_out;
  logic             table_full;
  int               errors;
  int               pending;
  int               idle_cycles;

  logic [ID_W-1:0]  peer_pool [POOL_SIZE];
  logic [SEQ_W-1:0] rx_base;

  always #5 clk = ~clk;

  anti_replay_sequence_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .is_broadcast(is_broadcast), .peer_id(peer_id),
    .received_sequence(received_sequence),
    .done(done), .accepted(accepted), .sequence_out(sequence_out),
    .table_full(table_full)
  );

  replay_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .is_broadcast(is_broadcast), .peer_id(peer_id),
    .received_sequence(received_sequence),
    .done(done), .accepted(accepted), .sequence_out(sequence_out),
    .table_full(table_full), .errors(errors), .pending(pending)
  );

  // Abort when neither an item nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one item after a gap and hold it until the block takes it
  task automatic issue_item(input cmd_t cmd, input logic bcast, input logic [ID_W-1:0] id,
                            input logic [SEQ_W-1:0] rx, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    is_broadcast = bcast;
    peer_id = id;
    received_sequence = rx;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    cmd_t             cmd;
    logic             bcast;
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] rx;
    int               sel;
    int               burst_left;
    int               gap;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: stale, repeated and fresh sequences on one unicast peer
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'h0000_0000, $urandom_range(0, 5));
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'h0000_0005, $urandom_range(0, 5));
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'h0000_0005, 0);
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'h0000_0004, $urandom_range(0, 5));
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'hFFFF_FFFF, 0);
    issue_item(CMD_CHECK, 1'b0, 16'h0001, 32'hFFFF_FFFF, $urandom_range(0, 5));
    // Directed: unicast sends on a known and a new peer
    issue_item(CMD_SEND, 1'b0, 16'h0001, 32'hFFFF_FFFF, 0);
    issue_item(CMD_SEND, 1'b0, 16'hFFFF, 32'h0000_0000, $urandom_range(0, 5));
    issue_item(CMD_SEND, 1'b0, 16'h0001, 32'h0000_0000, 0);
    // Directed: peer id zero lands on the first free slot and leaves it free
    issue_item(CMD_CHECK, 1'b0, 16'h0000, 32'h0000_0007, $urandom_range(0, 5));
    issue_item(CMD_SEND, 1'b0, 16'h0000, 32'h0000_0000, 0);
    issue_item(CMD_CHECK, 1'b0, 16'h0000, 32'h0000_0007, 0);
    issue_item(CMD_CHECK, 1'b0, 16'h1234, 32'h0000_0003, $urandom_range(0, 5));
    // Directed: broadcast table checks
    issue_item(CMD_CHECK, 1'b1, 16'h0001, 32'hFFFF_FFFF, $urandom_range(0, 5));
    issue_item(CMD_CHECK, 1'b1, 16'hFFFF, 32'h0000_0001, 0);
    issue_item(CMD_CHECK, 1'b1, 16'h0000, 32'h0000_0003, $urandom_range(0, 5));
    issue_item(CMD_CHECK, 1'b1, 16'hFFFF, 32'h0000_0001, 0);
    // Directed: broadcast sends back to back, peer id ignored
    issue_item(CMD_SEND, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, $urandom_range(1, 5));
    issue_item(CMD_SEND, 1'b1, 16'h0000, 32'h0000_0000, 0);
    issue_item(CMD_SEND, 1'b1, 16'hA5A5, 32'h5A5A_5A5A, 0);
    issue_item(CMD_SEND, 1'b0, 16'hFFFF, 32'h0000_0000, 0);
    issue_item(CMD_SEND, 1'b1, 16'h5A5A, 32'hA5A5_A5A5, 0);

    // Build a peer pool a little larger than one table so that both tables fill
    peer_pool[0] = 16'h0001;
    peer_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      peer_pool[i] = ID_W'($urandom_range(2, 16'hFFFE));
    end
    rx_base = 32'h0000_0100;
    burst_left = 0;

    // Random: mostly rising sequences on pooled peers, noise in the second half
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = $urandom_range(0, 1) ? CMD_SEND : CMD_CHECK;
      bcast = ($urandom_range(0, 9) < 3);
      if (n >= RANDOM_ITEMS / 2 && $urandom_range(0, 9) == 0) begin
        id = ID_W'($urandom_range(0, 16'hFFFF));
      end else if ($urandom_range(0, 39) == 0) begin
        id = '0;
      end else begin
        id = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      sel = $urandom_range(0, 99);
      if (n >= RANDOM_ITEMS / 2 && sel >= 93) begin
        if (sel >= 98) begin
          rx = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else begin
          rx = $urandom;
        end
      end else if (sel < 65) begin
        rx_base = rx_base + $urandom_range(0, 3);
        rx = rx_base;
      end else if (sel < 88) begin
        rx = rx_base - $urandom_range(0, 8);
      end else begin
        rx = $urandom_range(0, 15);
      end
      // Alternate stretches of back-to-back items with randomly gapped ones
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 49) == 0) begin
          burst_left = $urandom_range(10, 30);
        end
        gap = $urandom_range(0, 5);
      end
      issue_item(cmd, bcast, id, rx, gap);
    end
    start = 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (pending != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/arst_pkg.sv
sv/arst_update.sv
sv/anti_replay_sequence_table.sv
tb/replay_table_checker.sv
tb/tb_anti_replay_sequence_table.sv
